// ===== rtl/dne_pkg.sv =====
// shared types and constants of the depth normal estimator
package dne_pkg;

  // input item kind
  typedef enum logic {
    OP_POINT = 1'b0,
    OP_FLUSH = 1'b1
  } op_e;

  // configuration register index
  typedef enum logic {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_e;

  // control that travels with every pipeline stage
  typedef struct packed {
    logic live;
    logic fe;
    logic ok;
  } dne_side_t;

  localparam int CFG_BITS     = 11;
  localparam int RESET_WIDTH  = 640;
  localparam int RESET_HEIGHT = 480;

  // normalization datapath
  localparam int A_BITS     = 30;
  localparam int A_TOP      = 29;
  localparam int SQ_BITS    = 60;
  localparam int RAD_BITS   = 64;
  localparam int ROOT_STEPS = 32;
  localparam int LEN_BITS   = 32;
  localparam int Q_BITS     = 16;
  localparam int NUM_BITS   = 48;
  localparam int OUT_BITS   = 16;

  localparam logic [Q_BITS-1:0] POS_MAX = 16'd32767;
  localparam logic [Q_BITS-1:0] NEG_MAX = 16'd32768;

endpackage

// ===== rtl/dne_norm.sv =====
// unit-length scaling of the cross product: shift, square root and divide pipeline
module dne_norm import dne_pkg::*; #(
  parameter int NB = 51
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       adv_i,
  input  dne_side_t                  side_i,
  input  logic signed [NB-1:0]       n_x_i,
  input  logic signed [NB-1:0]       n_y_i,
  input  logic signed [NB-1:0]       n_z_i,
  output logic signed [OUT_BITS-1:0] norm_x_o,
  output logic signed [OUT_BITS-1:0] norm_y_o,
  output logic signed [OUT_BITS-1:0] norm_z_o,
  output dne_side_t                  side_o
);

  localparam int GN  = (NB + 7) / 8;
  localparam int GW  = (GN > 1) ? $clog2(GN) : 1;
  localparam int MW  = GN * 8;
  localparam int PSW = (GW + 3 > 6) ? GW + 3 : 6;

  logic signed [NB-1:0] n_in [3];
  assign n_in[0] = n_x_i;
  assign n_in[1] = n_y_i;
  assign n_in[2] = n_z_i;

  // stage 1: magnitudes and largest magnitude
  logic [NB-1:0] mag_d [3];
  logic [NB-1:0] m_d;
  always_comb begin
    m_d = '0;
    for (int i = 0; i < 3; i++) begin
      mag_d[i] = n_in[i][NB-1] ? NB'(-n_in[i]) : NB'(n_in[i]);
      if (mag_d[i] > m_d) m_d = mag_d[i];
    end
  end

  dne_side_t     s1_side_q;
  logic [NB-1:0] s1_mag_q [3];
  logic          s1_neg_q [3];
  logic [NB-1:0] s1_m_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s1_side_q <= '0;
    else if (adv_i) s1_side_q <= side_i;
  end
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s1_mag_q <= mag_d;
      s1_m_q   <= m_d;
      for (int i = 0; i < 3; i++) s1_neg_q[i] <= n_in[i][NB-1];
    end
  end

  // stage 2: top nonzero byte of the largest magnitude
  logic [MW-1:0] m_pad1;
  logic [GW-1:0] grp_d;
  always_comb begin
    m_pad1 = MW'(s1_m_q);
    grp_d  = '0;
    for (int g = 0; g < GN; g++) begin
      if (|m_pad1[g*8 +: 8]) grp_d = GW'(g);
    end
  end

  dne_side_t     s2_side_q;
  logic [NB-1:0] s2_mag_q [3];
  logic          s2_neg_q [3];
  logic [NB-1:0] s2_m_q;
  logic [GW-1:0] s2_grp_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s2_side_q <= '0;
    else if (adv_i) s2_side_q <= s1_side_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s2_mag_q <= s1_mag_q;
      s2_neg_q <= s1_neg_q;
      s2_m_q   <= s1_m_q;
      s2_grp_q <= grp_d;
    end
  end

  // stage 3: top bit within that byte
  logic [MW-1:0]  m_pad2;
  logic [7:0]     byte_sel;
  logic [2:0]     bit_d;
  logic [PSW-1:0] pos_d;
  always_comb begin
    m_pad2   = MW'(s2_m_q);
    byte_sel = m_pad2[s2_grp_q*8 +: 8];
    bit_d    = '0;
    for (int b = 0; b < 8; b++) begin
      if (byte_sel[b]) bit_d = 3'(b);
    end
    pos_d = PSW'({s2_grp_q, bit_d});
  end

  dne_side_t      s3_side_q;
  logic [NB-1:0]  s3_mag_q [3];
  logic           s3_neg_q [3];
  logic [PSW-1:0] s3_pos_q;
  logic           s3_zero_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s3_side_q <= '0;
    else if (adv_i) s3_side_q <= s2_side_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s3_mag_q  <= s2_mag_q;
      s3_neg_q  <= s2_neg_q;
      s3_pos_q  <= pos_d;
      s3_zero_q <= (s2_m_q == '0);
    end
  end

  // stage 4: align the largest magnitude to bit 29
  logic [A_BITS-1:0] a_d [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (s3_pos_q >= PSW'(A_TOP)) begin
        a_d[i] = A_BITS'(s3_mag_q[i] >> (s3_pos_q - PSW'(A_TOP)));
      end else begin
        a_d[i] = A_BITS'(s3_mag_q[i] << (PSW'(A_TOP) - s3_pos_q));
      end
    end
  end

  dne_side_t         s4_side_q;
  logic [A_BITS-1:0] s4_a_q [3];
  logic              s4_neg_q [3];
  logic              s4_zero_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s4_side_q <= '0;
    else if (adv_i) s4_side_q <= s3_side_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s4_a_q    <= a_d;
      s4_neg_q  <= s3_neg_q;
      s4_zero_q <= s3_zero_q;
    end
  end

  // stage 5: squares
  dne_side_t          s5_side_q;
  logic [SQ_BITS-1:0] s5_sq_q [3];
  logic [A_BITS-1:0]  s5_a_q [3];
  logic               s5_neg_q [3];
  logic               s5_zero_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s5_side_q <= '0;
    else if (adv_i) s5_side_q <= s4_side_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int i = 0; i < 3; i++) begin
        s5_sq_q[i] <= SQ_BITS'(s4_a_q[i]) * SQ_BITS'(s4_a_q[i]);
      end
      s5_a_q    <= s4_a_q;
      s5_neg_q  <= s4_neg_q;
      s5_zero_q <= s4_zero_q;
    end
  end

  // stage 6 and square root: one result bit per stage
  dne_side_t           rt_side_q [ROOT_STEPS+1];
  logic [RAD_BITS-1:0] rt_v_q    [ROOT_STEPS+1];
  logic [RAD_BITS-1:0] rt_r_q    [ROOT_STEPS+1];
  logic [A_BITS-1:0]   rt_a_q    [ROOT_STEPS+1][3];
  logic                rt_neg_q  [ROOT_STEPS+1][3];
  logic                rt_zero_q [ROOT_STEPS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) rt_side_q[0] <= '0;
    else if (adv_i) rt_side_q[0] <= s5_side_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      rt_v_q[0]    <= RAD_BITS'(s5_sq_q[0]) + RAD_BITS'(s5_sq_q[1]) + RAD_BITS'(s5_sq_q[2]);
      rt_r_q[0]    <= '0;
      rt_a_q[0]    <= s5_a_q;
      rt_neg_q[0]  <= s5_neg_q;
      rt_zero_q[0] <= s5_zero_q;
    end
  end

  for (genvar j = 0; j < ROOT_STEPS; j++) begin : g_root
    localparam logic [RAD_BITS-1:0] BITV = RAD_BITS'(1) << (2 * (ROOT_STEPS - 1 - j));
    logic [RAD_BITS-1:0] trial;
    logic                ge;
    assign trial = rt_r_q[j] + BITV;
    assign ge    = (rt_v_q[j] >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) rt_side_q[j+1] <= '0;
      else if (adv_i) rt_side_q[j+1] <= rt_side_q[j];
    end
    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        rt_v_q[j+1]    <= ge ? rt_v_q[j] - trial : rt_v_q[j];
        rt_r_q[j+1]    <= ge ? (rt_r_q[j] >> 1) + BITV : rt_r_q[j] >> 1;
        rt_a_q[j+1]    <= rt_a_q[j];
        rt_neg_q[j+1]  <= rt_neg_q[j];
        rt_zero_q[j+1] <= rt_zero_q[j];
      end
    end
  end

  // divider setup: rounded quotient of a * 65536 by twice the length
  logic [LEN_BITS-1:0] len;
  assign len = LEN_BITS'(rt_r_q[ROOT_STEPS]);

  dne_side_t           dv_side_q [Q_BITS+1];
  logic [NUM_BITS-1:0] dv_r_q    [Q_BITS+1][3];
  logic [Q_BITS-1:0]   dv_q_q    [Q_BITS+1][3];
  logic [LEN_BITS-1:0] dv_d_q    [Q_BITS+1];
  logic                dv_neg_q  [Q_BITS+1][3];
  logic                dv_zero_q [Q_BITS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) dv_side_q[0] <= '0;
    else if (adv_i) dv_side_q[0] <= rt_side_q[ROOT_STEPS];
  end
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int i = 0; i < 3; i++) begin
        dv_r_q[0][i] <= NUM_BITS'({rt_a_q[ROOT_STEPS][i], {Q_BITS{1'b0}}}) + NUM_BITS'(len);
        dv_q_q[0][i] <= '0;
      end
      dv_d_q[0]    <= {len[LEN_BITS-2:0], 1'b0};
      dv_neg_q[0]  <= rt_neg_q[ROOT_STEPS];
      dv_zero_q[0] <= rt_zero_q[ROOT_STEPS];
    end
  end

  // restoring division, one quotient bit per stage
  for (genvar j = 0; j < Q_BITS; j++) begin : g_div
    logic [NUM_BITS-1:0] trial;
    logic                ge [3];
    assign trial = NUM_BITS'(dv_d_q[j]) << (Q_BITS - 1 - j);
    always_comb begin
      for (int i = 0; i < 3; i++) ge[i] = (dv_r_q[j][i] >= trial);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) dv_side_q[j+1] <= '0;
      else if (adv_i) dv_side_q[j+1] <= dv_side_q[j];
    end
    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        for (int i = 0; i < 3; i++) begin
          dv_r_q[j+1][i] <= ge[i] ? dv_r_q[j][i] - trial : dv_r_q[j][i];
          dv_q_q[j+1][i] <= dv_q_q[j][i] |
                            (ge[i] ? Q_BITS'(1) << (Q_BITS - 1 - j) : '0);
        end
        dv_d_q[j+1]    <= dv_d_q[j];
        dv_neg_q[j+1]  <= dv_neg_q[j];
        dv_zero_q[j+1] <= dv_zero_q[j];
      end
    end
  end

  // saturate, apply sign, force zero for invalid or degenerate normals
  logic [OUT_BITS-1:0] res_d [3];
  logic [Q_BITS-1:0]   qs;
  always_comb begin
    qs = '0;
    for (int i = 0; i < 3; i++) begin
      if (dv_neg_q[Q_BITS][i]) begin
        qs       = (dv_q_q[Q_BITS][i] > NEG_MAX) ? NEG_MAX : dv_q_q[Q_BITS][i];
        res_d[i] = OUT_BITS'(-qs);
      end else begin
        qs       = (dv_q_q[Q_BITS][i] > POS_MAX) ? POS_MAX : dv_q_q[Q_BITS][i];
        res_d[i] = OUT_BITS'(qs);
      end
      if (!dv_side_q[Q_BITS].ok || dv_zero_q[Q_BITS]) res_d[i] = '0;
    end
  end

  // output register
  logic [OUT_BITS-1:0] out_q [3];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) side_o <= '0;
    else if (adv_i) side_o <= dv_side_q[Q_BITS];
  end
  always_ff @(posedge clk_i) begin
    if (adv_i) out_q <= res_d;
  end

  assign norm_x_o = $signed(out_q[0]);
  assign norm_y_o = $signed(out_q[1]);
  assign norm_z_o = $signed(out_q[2]);

endmodule

// ===== rtl/depth_normal_estimator_core.sv =====
// throughput: one transaction per cycle unless the output stalls; the 32-stage
//   square root and the 16-stage divider are fully pipelined, and the line store
//   reads are registered
// reset: counters and flush state clear, frame size returns to 640 x 480,
//   stage valid bits clear; line stores are not cleared and need no clearing pass
module depth_normal_estimator_core import dne_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int COORD_BITS = 24
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         op_i,
  input  logic signed [COORD_BITS-1:0] point_x_i,
  input  logic signed [COORD_BITS-1:0] point_y_i,
  input  logic signed [COORD_BITS-1:0] point_z_i,
  input  logic                         point_valid_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [OUT_BITS-1:0]   normal_x_o,
  output logic signed [OUT_BITS-1:0]   normal_y_o,
  output logic signed [OUT_BITS-1:0]   normal_z_o,
  output logic                         normal_valid_o,
  output logic                         frame_end_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic                         cfg_index_i,
  input  logic [CFG_BITS-1:0]          cfg_data_i
);

  localparam int CI    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int EW    = ((CI > CFG_BITS) ? CI : CFG_BITS) + 2;
  localparam int DEPTH = 2 * MAX_WIDTH;
  localparam int AW    = $clog2(DEPTH);
  localparam int PW    = 3 * COORD_BITS + 1;
  localparam int DW    = COORD_BITS + 1;
  localparam int PB    = 2 * DW;
  localparam int NB    = PB + 1;

  // configuration registers
  logic [CFG_BITS-1:0] cfg_w_q, cfg_h_q;
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_w_q <= CFG_BITS'(RESET_WIDTH);
      cfg_h_q <= CFG_BITS'(RESET_HEIGHT);
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_FRAME_WIDTH:  cfg_w_q <= cfg_data_i;
        REG_FRAME_HEIGHT: cfg_h_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // effective frame size
  logic [EW-1:0]       w_ext, w_eff;
  logic [CFG_BITS-1:0] h_eff;
  assign w_ext = EW'(cfg_w_q);
  assign w_eff = (w_ext == '0) ? EW'(1) :
                 (w_ext > EW'(MAX_WIDTH)) ? EW'(MAX_WIDTH) : w_ext;
  assign h_eff = (cfg_h_q == '0) ? CFG_BITS'(1) : cfg_h_q;

  // raster position
  logic [CI-1:0]       col_q, flush_q;
  logic [CFG_BITS-1:0] row_q;
  logic                drain_q;

  logic adv, take, is_flush, pt_go, fl_go, emit, flush_last;
  assign adv        = !out_valid_o || out_ready_i;
  assign in_ready_o = adv;
  assign take       = in_valid_i && adv;
  assign is_flush   = (op_e'(op_i) == OP_FLUSH);
  assign pt_go      = take && !is_flush && !drain_q;
  assign fl_go      = take && is_flush && drain_q;
  assign flush_last = (EW'(flush_q) + EW'(1)) >= w_eff;
  assign emit       = fl_go || (pt_go && row_q != '0);

  // neighbour columns and line store slots
  logic [CI-1:0] col_cur, cl, cr;
  logic [EW-1:0] c1;
  logic          slot_cen, slot_up, up_cen;
  always_comb begin
    if (is_flush) begin
      col_cur = (EW'(flush_q) < w_eff) ? flush_q : CI'(w_eff - EW'(1));
    end else begin
      col_cur = col_q;
    end
    c1       = EW'(col_cur) + EW'(1);
    cl       = (col_cur == '0) ? '0 : col_cur - CI'(1);
    cr       = (c1 < w_eff) ? CI'(c1) : CI'(w_eff - EW'(1));
    slot_cen = is_flush ? row_q[0] : ~row_q[0];
    slot_up  = ~slot_cen;
    up_cen   = is_flush ? (row_q == '0) : (row_q == CFG_BITS'(1));
  end

  // counter update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      flush_q <= '0;
      drain_q <= 1'b0;
    end else if (pt_go) begin
      if (c1 >= w_eff) begin
        col_q <= '0;
        if ((CFG_BITS + 1)'(row_q) + 1'b1 >= (CFG_BITS + 1)'(h_eff)) drain_q <= 1'b1;
        else row_q <= row_q + CFG_BITS'(1);
      end else begin
        col_q <= CI'(c1);
      end
    end else if (fl_go) begin
      if (flush_last) begin
        col_q   <= '0;
        row_q   <= '0;
        flush_q <= '0;
        drain_q <= 1'b0;
      end else begin
        flush_q <= flush_q + CI'(1);
      end
    end
  end

  function automatic logic [AW-1:0] loc(input logic slot, input logic [CI-1:0] col);
    loc = slot ? AW'(MAX_WIDTH) + AW'(col) : AW'(col);
  endfunction

  // line stores: four copies, one per neighbour read
  logic [AW-1:0] rd_addr [4];
  logic [PW-1:0] rd_q [4];
  logic [AW-1:0] wr_addr;
  logic [PW-1:0] wr_data;
  assign rd_addr[0] = loc(slot_cen, col_cur);
  assign rd_addr[1] = loc(slot_up, col_cur);
  assign rd_addr[2] = loc(slot_cen, cl);
  assign rd_addr[3] = loc(slot_cen, cr);
  assign wr_addr    = loc(row_q[0], col_q);
  assign wr_data    = {point_valid_i, point_x_i, point_y_i, point_z_i};

  for (genvar k = 0; k < 4; k++) begin : g_store
    logic [PW-1:0] line_mem [DEPTH];
    always_ff @(posedge clk_i) begin
      if (pt_go) line_mem[wr_addr] <= wr_data;
      if (adv) rd_q[k] <= line_mem[rd_addr[k]];
    end
  end

  // stage 1: read data arrives, item control registered
  dne_side_t     s1_side_q;
  logic          s1_up_cen_q, s1_flush_q;
  logic [PW-1:0] s1_p_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s1_side_q <= '0;
    else if (adv) s1_side_q <= '{live: emit, fe: fl_go && flush_last, ok: 1'b0};
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_up_cen_q <= up_cen;
      s1_flush_q  <= is_flush;
      s1_p_q      <= wr_data;
    end
  end

  // neighbour differences
  logic [PW-1:0]                up_w, dn_w;
  logic signed [DW-1:0]         ax_d, ay_d, az_d, bx_d, by_d, bz_d;
  logic                         all_ok;
  assign up_w   = s1_up_cen_q ? rd_q[0] : rd_q[1];
  assign dn_w   = s1_flush_q ? rd_q[0] : s1_p_q;
  assign all_ok = rd_q[0][PW-1] && up_w[PW-1] && dn_w[PW-1] && rd_q[2][PW-1] && rd_q[3][PW-1];

  assign ax_d = DW'($signed(rd_q[2][3*COORD_BITS-1:2*COORD_BITS]))
              - DW'($signed(rd_q[3][3*COORD_BITS-1:2*COORD_BITS]));
  assign ay_d = DW'($signed(rd_q[2][2*COORD_BITS-1:COORD_BITS]))
              - DW'($signed(rd_q[3][2*COORD_BITS-1:COORD_BITS]));
  assign az_d = DW'($signed(rd_q[2][COORD_BITS-1:0]))
              - DW'($signed(rd_q[3][COORD_BITS-1:0]));
  assign bx_d = DW'($signed(dn_w[3*COORD_BITS-1:2*COORD_BITS]))
              - DW'($signed(up_w[3*COORD_BITS-1:2*COORD_BITS]));
  assign by_d = DW'($signed(dn_w[2*COORD_BITS-1:COORD_BITS]))
              - DW'($signed(up_w[2*COORD_BITS-1:COORD_BITS]));
  assign bz_d = DW'($signed(dn_w[COORD_BITS-1:0]))
              - DW'($signed(up_w[COORD_BITS-1:0]));

  // stage 2: differences registered
  dne_side_t            s2_side_q;
  logic signed [DW-1:0] ax_q, ay_q, az_q, bx_q, by_q, bz_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s2_side_q <= '0;
    else if (adv) s2_side_q <= '{live: s1_side_q.live, fe: s1_side_q.fe, ok: all_ok};
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      ax_q <= ax_d;
      ay_q <= ay_d;
      az_q <= az_d;
      bx_q <= bx_d;
      by_q <= by_d;
      bz_q <= bz_d;
    end
  end

  // stage 3: six partial products
  dne_side_t            s3_side_q;
  logic signed [PB-1:0] pr_q [6];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s3_side_q <= '0;
    else if (adv) s3_side_q <= s2_side_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      pr_q[0] <= PB'(ay_q) * PB'(bz_q);
      pr_q[1] <= PB'(az_q) * PB'(by_q);
      pr_q[2] <= PB'(az_q) * PB'(bx_q);
      pr_q[3] <= PB'(ax_q) * PB'(bz_q);
      pr_q[4] <= PB'(ax_q) * PB'(by_q);
      pr_q[5] <= PB'(ay_q) * PB'(bx_q);
    end
  end

  // stage 4: cross product
  dne_side_t            s4_side_q;
  logic signed [NB-1:0] nx_q, ny_q, nz_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s4_side_q <= '0;
    else if (adv) s4_side_q <= s3_side_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      nx_q <= NB'(pr_q[0]) - NB'(pr_q[1]);
      ny_q <= NB'(pr_q[2]) - NB'(pr_q[3]);
      nz_q <= NB'(pr_q[4]) - NB'(pr_q[5]);
    end
  end

  // normalization back end, its last stage is the output register
  dne_side_t out_side;
  dne_norm #(
    .NB (NB)
  ) u_norm (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .side_i   (s4_side_q),
    .n_x_i    (nx_q),
    .n_y_i    (ny_q),
    .n_z_i    (nz_q),
    .norm_x_o (normal_x_o),
    .norm_y_o (normal_y_o),
    .norm_z_o (normal_z_o),
    .side_o   (out_side)
  );

  assign out_valid_o    = out_side.live;
  assign normal_valid_o = out_side.ok;
  assign frame_end_o    = out_side.fe;

`ifndef ASSERT_OFF
  // a new row never starts while the last row drains
  a_drain_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    drain_q |-> col_q == '0) else $error("column count nonzero while draining");

  // the flush count only moves while draining
  a_flush_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !drain_q |-> flush_q == '0) else $error("flush count nonzero outside drain");

  // an invalid normal is all zero
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !normal_valid_o |->
      normal_x_o == '0 && normal_y_o == '0 && normal_z_o == '0)
    else $error("invalid normal carries nonzero components");

  // frame end only marks a flush result, which never comes without draining first
  a_fe_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_side_q.fe |-> s1_side_q.live) else $error("frame end on an empty stage");
`endif

endmodule
